@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside of reset.
`define BFBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("allocator assertion failed");
// Checks that a condition implies a consequence in the same cycle.
`define BFBA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator implication failed");
`else
`define BFBA_ASSERT(lbl, clk, rst, prop)
`define BFBA_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/bfba_pkg.sv @@
// ----------------------------------------------------------------------------
// Best-fit allocator package
// Sizes, request and response codes and the structs that link the cells.
// ----------------------------------------------------------------------------
package bfba_pkg;

   // Table geometry.
   localparam int BLOCKS    = 32;
   localparam int SIZE_BITS = 16;
   localparam int IDX_BITS  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

   // Field widths of the request and response.
   localparam int OP_BITS     = 1;
   localparam int BINDEX_BITS = 5;
   localparam int AMOUNT_BITS = 16;
   localparam int PID_BITS    = 8;
   localparam int STATUS_BITS = 2;
   localparam int BIU_BITS    = 6;

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_FIELD_BITS = BINDEX_BITS + AMOUNT_BITS + PID_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = BINDEX_BITS + AMOUNT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Compare widths that hold both operands without loss.
   localparam int WIDE_BITS = (SIZE_BITS > AMOUNT_BITS) ? SIZE_BITS : AMOUNT_BITS;
   localparam int CMP_BITS  = (IDX_BITS + 1 > BIU_BITS) ? IDX_BITS + 1 : BIU_BITS;

   // Reset value of the block count register.
   localparam logic [BIU_BITS-1:0] BIU_RESET = 6'd32;

   // Request kinds.
   localparam logic [OP_BITS-1:0] OP_LOAD  = 1'b0;
   localparam logic [OP_BITS-1:0] OP_ALLOC = 1'b1;

   // Response status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_LOADED    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ALLOCATED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_FIT    = 2'd2;

   // Search token that travels from cell to cell.
   typedef struct packed {
      logic                 valid;
      logic                 found;
      logic [IDX_BITS-1:0]  idx;
      logic [SIZE_BITS-1:0] size;
   } token_type;

   // Update broadcast to the selected cell.
   typedef struct packed {
      logic                 take;
      logic [SIZE_BITS-1:0] size;
      logic [PID_BITS-1:0]  owner;
   } update_type;

endpackage

@@ hw/rtl/best_fit_block_allocator_core.sv @@
// Allocate request: the search token walks the cell chain one block per cycle; the
// winner is then latched, and the block update and the response are registered together.
// Load request: the request is latched and the sequencer moves to its done state, where
// the block update and the response are registered. One request is in work at a time,
// and a waiting response holds the next.
// Synchronous active-high reset clears every block to size zero, no owner, count 32.
// ----------------------------------------------------------------------------
// Best-fit block allocator core
// Sequencer, request latch, response register and the cell chain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module best_fit_block_allocator_core (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // block_index [4:0], amount [20:5], process_id [28:21], zero pad
   input  logic [bfba_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // op [0]
   input  logic [bfba_pkg::OP_BITS-1:0]        req_tuser,
   // Response stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // chosen_block [4:0], space_left [20:5], zero pad
   output logic [bfba_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // status [1:0]
   output logic [bfba_pkg::STATUS_BITS-1:0]    rsp_tuser,
   // Block count register.
   input  logic                                csr_we,
   input  logic [bfba_pkg::BIU_BITS-1:0]       csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam int AMT_LO = bfba_pkg::BINDEX_BITS;
   localparam int PID_LO = AMT_LO + bfba_pkg::AMOUNT_BITS;

   state_type                          state_ff, state_in;
   logic [bfba_pkg::OP_BITS-1:0]       op_ff;
   logic [bfba_pkg::BINDEX_BITS-1:0]   idx_ff;
   logic [bfba_pkg::AMOUNT_BITS-1:0]   amount_ff;
   logic [bfba_pkg::PID_BITS-1:0]      pid_ff;
   logic                               start_ff;
   logic [bfba_pkg::BIU_BITS-1:0]      biu_ff;
   bfba_pkg::token_type                best_ff;
   logic                               rsp_valid_ff;
   logic [bfba_pkg::STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [bfba_pkg::BINDEX_BITS-1:0]   rsp_block_ff, rsp_block_in;
   logic [bfba_pkg::AMOUNT_BITS-1:0]   rsp_left_ff, rsp_left_in;

   bfba_pkg::token_type                scan_result;
   bfba_pkg::update_type               wr_data;
   logic [bfba_pkg::IDX_BITS-1:0]      wr_idx;
   logic                               wr_en;
   logic                               req_fire;
   logic                               finish;
   logic                               load_in_range;
   logic [bfba_pkg::SIZE_BITS-1:0]     load_size;
   logic [bfba_pkg::SIZE_BITS-1:0]     alloc_size;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign finish     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_tuser == bfba_pkg::OP_ALLOC) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_result.valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
         biu_ff   <= bfba_pkg::BIU_RESET;
      end else begin
         state_ff <= state_in;
         start_ff <= req_fire && (req_tuser == bfba_pkg::OP_ALLOC);
         if (csr_we) begin
            biu_ff <= csr_wdata;
         end
      end
   end

   // Request latch.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_tuser;
         idx_ff    <= req_tdata[AMT_LO-1:0];
         amount_ff <= req_tdata[PID_LO-1:AMT_LO];
         pid_ff    <= req_tdata[PID_LO+bfba_pkg::PID_BITS-1:PID_LO];
      end
      if ((state_ff == ST_SCAN) && scan_result.valid) begin
         best_ff <= scan_result;
      end
   end

   // Search chain.
   bfba_chain u_chain (
      .clock         (clock),
      .reset         (reset),
      .start         (start_ff),
      .blocks_in_use (biu_ff),
      .amount        (amount_ff),
      .wr_en         (wr_en),
      .wr_idx        (wr_idx),
      .wr_data       (wr_data),
      .result        (scan_result)
   );

   // Write back and response contents.
   always_comb begin
      load_in_range = 32'(idx_ff) < 32'(bfba_pkg::BLOCKS);
      load_size     = bfba_pkg::SIZE_BITS'(amount_ff);
      alloc_size    = bfba_pkg::SIZE_BITS'(bfba_pkg::WIDE_BITS'(best_ff.size) -
                                           bfba_pkg::WIDE_BITS'(amount_ff));
      wr_data.owner = pid_ff;
      if (op_ff == bfba_pkg::OP_LOAD) begin
         wr_en         = finish && load_in_range;
         wr_idx        = bfba_pkg::IDX_BITS'(idx_ff);
         wr_data.take  = 1'b0;
         wr_data.size  = load_size;
         rsp_status_in = bfba_pkg::STATUS_LOADED;
         rsp_block_in  = idx_ff;
         rsp_left_in   = load_in_range ? bfba_pkg::AMOUNT_BITS'(load_size) : '0;
      end else begin
         wr_en         = finish && best_ff.found;
         wr_idx        = best_ff.idx;
         wr_data.take  = 1'b1;
         wr_data.size  = alloc_size;
         if (best_ff.found) begin
            rsp_status_in = bfba_pkg::STATUS_ALLOCATED;
            rsp_block_in  = bfba_pkg::BINDEX_BITS'(best_ff.idx);
            rsp_left_in   = bfba_pkg::AMOUNT_BITS'(alloc_size);
         end else begin
            rsp_status_in = bfba_pkg::STATUS_NO_FIT;
            rsp_block_in  = '0;
            rsp_left_in   = '0;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_block_ff  <= rsp_block_in;
         rsp_left_ff   <= rsp_left_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = bfba_pkg::RSP_DATA_BITS'({rsp_left_ff, rsp_block_ff});

   // The sequencer is always in exactly one state.
   `BFBA_ASSERT(a_state_onehot, clock, reset, $onehot(state_ff))
   // A search token only leaves the chain while a scan is running.
   `BFBA_ASSERT_IMPLY(a_token_in_scan, clock, reset, scan_result.valid, state_ff == ST_SCAN)
   // A no-fit response carries zero block and space fields.
   `BFBA_ASSERT_IMPLY(a_nofit_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff == bfba_pkg::STATUS_NO_FIT),
      (rsp_block_ff == '0) && (rsp_left_ff == '0))

endmodule

@@ hw/rtl/bfba_cell.sv @@
// ----------------------------------------------------------------------------
// Allocator cell
// Holds one block and compares it against the search token passing through.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfba_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bfba_pkg::IDX_BITS-1:0]  my_index,
   input  logic                           eligible,
   input  logic [bfba_pkg::AMOUNT_BITS-1:0] amount,
   input  bfba_pkg::token_type            tok_in,
   output bfba_pkg::token_type            tok_out,
   input  logic                           wr_sel,
   input  bfba_pkg::update_type           wr_data
);

   logic [bfba_pkg::SIZE_BITS-1:0] size_ff;
   logic [bfba_pkg::PID_BITS-1:0]  owner_ff;
   logic                           owned_ff;
   bfba_pkg::token_type            tok_ff;
   bfba_pkg::token_type            tok_in_w;
   logic                           fits;
   logic                           better;

   // A block fits when it takes part and holds at least the request.
   always_comb begin
      fits   = eligible &&
               (bfba_pkg::WIDE_BITS'(size_ff) >= bfba_pkg::WIDE_BITS'(amount));
      better = fits && (!tok_in.found || (size_ff < tok_in.size));
      tok_in_w = tok_in;
      if (better) begin
         tok_in_w.found = 1'b1;
         tok_in_w.idx   = my_index;
         tok_in_w.size  = size_ff;
      end
   end

   // Token stage toward the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_w;
      end
   end

   assign tok_out = tok_ff;

   // Block state, written by a load or a successful allocation.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= '0;
         owner_ff <= '0;
         owned_ff <= 1'b0;
      end else if (wr_sel) begin
         size_ff <= wr_data.size;
         if (wr_data.take) begin
            owner_ff <= wr_data.owner;
            owned_ff <= 1'b1;
         end
      end
   end

   // An owner is only ever recorded together with the owned bit.
   `BFBA_ASSERT_IMPLY(a_owner_needs_owned, clock, reset, !owned_ff, owner_ff == '0)

endmodule

@@ hw/rtl/bfba_chain.sv @@
// ----------------------------------------------------------------------------
// Allocator cell chain
// A row of cells; the search token moves one cell per cycle.
// ----------------------------------------------------------------------------
module bfba_chain (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bfba_pkg::BIU_BITS-1:0]    blocks_in_use,
   input  logic [bfba_pkg::AMOUNT_BITS-1:0] amount,
   input  logic                             wr_en,
   input  logic [bfba_pkg::IDX_BITS-1:0]    wr_idx,
   input  bfba_pkg::update_type             wr_data,
   output bfba_pkg::token_type              result
);

   bfba_pkg::token_type link [bfba_pkg::BLOCKS+1];

   // A fresh token enters the first cell with nothing found yet.
   assign link[0] = '{valid: start, found: 1'b0, idx: '0, size: '0};

   // One cell per block.
   for (genvar k = 0; k < bfba_pkg::BLOCKS; k++) begin : g_cell
      logic eligible;
      logic wr_sel;

      assign eligible = bfba_pkg::CMP_BITS'(k) < bfba_pkg::CMP_BITS'(blocks_in_use);
      assign wr_sel   = wr_en && (wr_idx == bfba_pkg::IDX_BITS'(k));

      bfba_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .my_index (bfba_pkg::IDX_BITS'(k)),
         .eligible (eligible),
         .amount   (amount),
         .tok_in   (link[k]),
         .tok_out  (link[k+1]),
         .wr_sel   (wr_sel),
         .wr_data  (wr_data)
      );
   end

   assign result = link[bfba_pkg::BLOCKS];

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Best-fit block allocator testbench
// Drives load and allocate requests into the allocator core, predicts every
// response with a cycle-free model of the block table, and checks each
// response field by field. The block count register is swept through its
// extremes between phases, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

   // One request as the allocator sees it.
   typedef struct packed {
      logic [bfba_pkg::OP_BITS-1:0]     op;
      logic [bfba_pkg::BINDEX_BITS-1:0] block_index;
      logic [bfba_pkg::AMOUNT_BITS-1:0] amount;
      logic [bfba_pkg::PID_BITS-1:0]    owner_pid;
   } alloc_request_type;

   // One response: the status, the block it concerns and the space left in it.
   typedef struct packed {
      logic [bfba_pkg::STATUS_BITS-1:0] status;
      logic [bfba_pkg::BINDEX_BITS-1:0] chosen_block;
      logic [bfba_pkg::SIZE_BITS-1:0]   space_left;
   } alloc_outcome_type;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [bfba_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [bfba_pkg::OP_BITS-1:0]       req_tuser = bfba_pkg::OP_LOAD;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [bfba_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic [bfba_pkg::STATUS_BITS-1:0]   rsp_tuser;
   logic                               csr_we = 1'b0;
   logic [bfba_pkg::BIU_BITS-1:0]      csr_wdata = '0;

   // Mirror of the allocator state.
   logic [bfba_pkg::SIZE_BITS-1:0] mirror_size [bfba_pkg::BLOCKS];
   logic [bfba_pkg::PID_BITS-1:0]  block_owner [bfba_pkg::BLOCKS];
   logic                           block_owned [bfba_pkg::BLOCKS];
   logic [bfba_pkg::BIU_BITS-1:0]  block_count;

   alloc_outcome_type outcome_queue [$];
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;

   // Idling controls for the sender and the receiver.
   bit          sender_idle = 1'b0;
   bit          receiver_stalls = 1'b0;
   int unsigned burst_left = 0;
   int unsigned ready_timer = 0;

   best_fit_block_allocator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Applies one request to the mirrored table and returns its response.
   function automatic alloc_outcome_type best_fit_outcome(input alloc_request_type r);
      alloc_outcome_type              res;
      int                             search_limit;
      int                             best;
      logic [bfba_pkg::SIZE_BITS-1:0] best_size;
      best = -1;
      best_size = '0;
      res = '0;
      if (r.op == bfba_pkg::OP_LOAD) begin
         res.status = bfba_pkg::STATUS_LOADED;
         res.chosen_block = r.block_index;
         if (r.block_index < bfba_pkg::BLOCKS) begin
            mirror_size[r.block_index] = r.amount[bfba_pkg::SIZE_BITS-1:0];
            res.space_left = mirror_size[r.block_index];
         end
         return res;
      end
      // A count above the table size searches the whole table.
      search_limit = (block_count > bfba_pkg::BLOCKS) ? bfba_pkg::BLOCKS : int'(block_count);
      for (int k = 0; k < search_limit; k++) begin
         if (mirror_size[k] >= r.amount && (best < 0 || mirror_size[k] < best_size)) begin
            best = k;
            best_size = mirror_size[k];
         end
      end
      if (best < 0) begin
         res.status = bfba_pkg::STATUS_NO_FIT;
         return res;
      end
      mirror_size[best] = best_size - r.amount;
      block_owner[best] = r.owner_pid;
      block_owned[best] = 1'b1;
      res.status = bfba_pkg::STATUS_ALLOCATED;
      res.chosen_block = best[bfba_pkg::BINDEX_BITS-1:0];
      res.space_left = mirror_size[best];
      return res;
   endfunction

   // Sends one request, idling between bursts, and records its response.
   task automatic send_request(input alloc_request_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = 0;
         if (sender_idle) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 45) : $urandom_range(0, 4);
         end
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {{(bfba_pkg::REQ_DATA_BITS - bfba_pkg::REQ_FIELD_BITS){1'b0}},
                     r.owner_pid, r.amount, r.block_index};
      do @(posedge clock); while (!req_tready);
      outcome_queue.push_back(best_fit_outcome(r));
   endtask

   // Holds the request stream until every expected response has arrived.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outcome_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_block_count(input logic [bfba_pkg::BIU_BITS-1:0] value);
      drain_responses();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      block_count = value;
   endtask

   task automatic send_load(input int idx, input int amount);
      alloc_request_type r;
      r.op = bfba_pkg::OP_LOAD;
      r.block_index = idx[bfba_pkg::BINDEX_BITS-1:0];
      r.amount = amount[bfba_pkg::AMOUNT_BITS-1:0];
      r.owner_pid = bfba_pkg::PID_BITS'($urandom);
      send_request(r);
   endtask

   task automatic send_alloc(input int amount, input int pid);
      alloc_request_type r;
      r.op = bfba_pkg::OP_ALLOC;
      r.block_index = bfba_pkg::BINDEX_BITS'($urandom);
      r.amount = amount[bfba_pkg::AMOUNT_BITS-1:0];
      r.owner_pid = pid[bfba_pkg::PID_BITS-1:0];
      send_request(r);
   endtask

   // Best fit, ties, zero requests and owned blocks staying eligible.
   task automatic test_directed_fits();
      sender_idle = 1'b0;
      receiver_stalls = 1'b0;
      // Every block starts at size zero: a zero request takes block 0.
      send_alloc(0, 8'h00);
      send_alloc(1, 8'hFF);
      send_load(31, 16'hFFFF);
      send_load(5, 100);
      send_load(6, 100);
      // Tie between blocks 5 and 6: the lower index wins.
      send_alloc(100, 8'h55);
      send_alloc(100, 8'hAA);
      send_alloc(16'hFFFF, 8'hFF);
      send_alloc(1, 8'h01);
      // Reloading an owned block keeps it eligible.
      send_load(31, 16'hFFFF);
      send_alloc(16'hFFFF, 8'h80);
      send_load(10, 16'hAAAA);
      send_load(11, 16'h5555);
      send_alloc(16'h5555, 8'hAA);
      send_alloc(1, 8'h55);
      send_alloc(0, 8'h7F);
      send_load(0, 16'h0000);
      send_load(31, 16'h8000);
   endtask

   // Block count at zero, one, the table size and the register maximum.
   task automatic test_block_count_extremes();
      write_block_count(6'd0);
      send_load(0, 16'h1234);
      send_alloc(0, 8'h11);
      send_alloc(16'h0010, 8'h22);
      write_block_count(6'd1);
      send_alloc(16'h0234, 8'h33);
      send_alloc(16'h2000, 8'h44);
      write_block_count(6'd63);
      send_load(31, 16'h0001);
      send_alloc(1, 8'h66);
      write_block_count(6'd32);
      send_alloc(0, 8'h77);
   endtask

   // Random loads and allocations under several block counts.
   task automatic test_random_traffic();
      logic [bfba_pkg::BIU_BITS-1:0] counts [8];
      int                            items [8];
      alloc_request_type             r;
      int                            probe;
      int                            span;
      counts = '{6'd32, 6'd1, 6'd63, 6'd17, 6'd0, 6'd2, 6'd32, 6'd32};
      items  = '{240, 200, 240, 220, 60, 200, 260, 300};
      counts[3] = bfba_pkg::BIU_BITS'($urandom_range(3, 31));
      for (int phase = 0; phase < 8; phase++) begin
         write_block_count(counts[phase]);
         sender_idle = phase[0];
         receiver_stalls = (phase % 3) != 0;
         span = (counts[phase] == 0) ? 1 :
                ((counts[phase] > bfba_pkg::BLOCKS) ? bfba_pkg::BLOCKS : counts[phase]);
         for (int n = 0; n < items[phase]; n++) begin
            // Occasionally let the allocator run completely dry.
            if ($urandom_range(0, 99) == 0) drain_responses();
            r.owner_pid = bfba_pkg::PID_BITS'($urandom);
            r.block_index = bfba_pkg::BINDEX_BITS'($urandom);
            probe = $urandom_range(0, span - 1);
            if ($urandom_range(0, 99) < 45) begin
               r.op = bfba_pkg::OP_LOAD;
               if ($urandom_range(0, 9) < 7) r.block_index = bfba_pkg::BINDEX_BITS'(probe);
               r.amount = ($urandom_range(0, 3) == 0) ?
                          bfba_pkg::AMOUNT_BITS'($urandom_range(0, 64)) :
                          bfba_pkg::AMOUNT_BITS'($urandom);
            end else begin
               r.op = bfba_pkg::OP_ALLOC;
               case ($urandom_range(0, 9))
                  0, 1:    r.amount = bfba_pkg::AMOUNT_BITS'($urandom);
                  2:       r.amount = bfba_pkg::AMOUNT_BITS'($urandom_range(0, 15));
                  3, 4, 5: r.amount = mirror_size[probe];
                  6:       r.amount = mirror_size[probe] + 1'b1;
                  7:       r.amount = mirror_size[probe] - 1'b1;
                  8:       r.amount = '1;
                  default: r.amount = '0;
               endcase
            end
            send_request(r);
         end
      end
   endtask

   // Receiver: always ready, or alternating ready and stall stretches of random length when stalls are on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_timer <= 0;
      end else if (!receiver_stalls) begin
         rsp_tready <= 1'b1;
      end else if (ready_timer == 0) begin
         rsp_tready <= !rsp_tready;
         ready_timer <= rsp_tready ? $urandom_range(0, 20) : $urandom_range(1, 12);
      end else begin
         ready_timer <= ready_timer - 1;
      end
   end

   // Response checker: every accepted response against the oldest expectation.
   always @(posedge clock) begin
      alloc_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_queue.size() == 0) begin
            $error("unexpected response: status %0d, chosen_block %0d, space_left %0d",
                   rsp_tuser, rsp_tdata[4:0], rsp_tdata[20:5]);
            mismatch_count++;
         end else begin
            want = outcome_queue.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[4:0] !== want.chosen_block) begin
               $error("chosen_block: expected %0d, actual %0d", want.chosen_block,
                      rsp_tdata[4:0]);
               mismatch_count++;
            end
            if (rsp_tdata[20:5] !== want.space_left) begin
               $error("space_left: expected %0d, actual %0d", want.space_left,
                      rsp_tdata[20:5]);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** best_fit_block_allocator_core: FAILED **");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < bfba_pkg::BLOCKS; k++) begin
         mirror_size[k] = '0;
         block_owner[k] = '0;
         block_owned[k] = 1'b0;
      end
      block_count = bfba_pkg::BIU_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_fits();
      test_block_count_extremes();
      test_random_traffic();
      drain_responses();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** best_fit_block_allocator_core: PASSED **");
      end else begin
         $display("** best_fit_block_allocator_core: FAILED **");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/bfba_pkg.sv
hw/rtl/bfba_cell.sv
hw/rtl/bfba_chain.sv
hw/rtl/best_fit_block_allocator_core.sv
dv/tb_top.sv
